@@ rtl/mclb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclb_pkg
// Shared types and constants of the multi-channel LED blinker: command codes,
// field widths and the control and status groups of one blink channel.
// ----------------------------------------------------------------------------
package mclb_pkg;

	localparam int CMD_W      = 3;
	localparam int IDX_W      = 3;
	localparam int PERIOD_W   = 16;
	localparam int DURATION_W = 16;
	localparam int PHASE_W    = 16;
	localparam int ELAPSED_W  = 17;
	localparam int OUT_W      = 7;

	// input transaction: command, led_index, period_ms, duration_ms, padded to bytes
	localparam int IN_BITS  = CMD_W + IDX_W + PERIOD_W + DURATION_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	// output transaction: led_state, blinking, padded to bytes
	localparam int OUT_BITS = 2 * OUT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_LED_ON  = 3'd3,
		CMD_LED_OFF = 3'd4
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic start;
		logic stop;
		logic led_on;
		logic led_off;
	} chan_ctrl_t;

	typedef struct packed {
		logic led;
		logic active;
	} chan_stat_t;

endpackage
`default_nettype wire

@@ rtl/mclb_channel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclb_channel
// One blink channel: holds its LED and active bits, phase and elapsed counts
// and the stored period and duration, and works out the next state for one
// decoded command.
// ----------------------------------------------------------------------------
module mclb_channel
	import mclb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire chan_ctrl_t            ctrl,
	input  wire logic [PERIOD_W-1:0]   period,
	input  wire logic [DURATION_W-1:0] duration,
	output chan_stat_t                 stat,
	output chan_stat_t                 stat_next
);

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	logic                  led_q;
	logic                  active_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [DURATION_W-1:0] duration_q;

	logic                  led_d;
	logic                  active_d;
	logic [PHASE_W-1:0]    phase_d;
	logic [ELAPSED_W-1:0]  elapsed_d;

	logic [PERIOD_W-1:0]   per_eff;
	logic [ELAPSED_W-1:0]  elapsed_inc;
	logic [PHASE_W:0]      phase_inc;
	logic [PHASE_W-1:0]    phase_wrap;

	always_comb begin
		per_eff     = (period_q == '0) ? PERIOD_W'(1) : period_q;
		elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + ELAPSED_W'(1) : elapsed_q;
		phase_inc   = {1'b0, phase_q} + (PHASE_W+1)'(1);
		phase_wrap  = (phase_inc >= {1'b0, per_eff}) ? '0 : phase_inc[PHASE_W-1:0];

		led_d     = led_q;
		active_d  = active_q;
		phase_d   = phase_q;
		elapsed_d = elapsed_q;

		if (ctrl.tick && active_q) begin
			elapsed_d = elapsed_inc;
			phase_d   = phase_wrap;
			// run length exhausted: channel drops out and the led goes dark
			if ((duration_q != '0) && (elapsed_inc > {1'b0, duration_q})) begin
				active_d = 1'b0;
				led_d    = 1'b0;
			end else begin
				led_d = (phase_wrap > (per_eff >> 1));
			end
		end
		if (ctrl.start) begin
			active_d  = 1'b1;
			phase_d   = '0;
			elapsed_d = '0;
		end
		if (ctrl.stop) begin
			active_d = 1'b0;
			led_d    = 1'b0;
		end
		if (ctrl.led_on) begin
			led_d = 1'b1;
		end
		if (ctrl.led_off) begin
			led_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q     <= 1'b0;
			active_q  <= 1'b0;
			phase_q   <= '0;
			elapsed_q <= '0;
		end else begin
			led_q     <= led_d;
			active_q  <= active_d;
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			period_q   <= period;
			duration_q <= duration;
		end
	end

	assign stat      = '{led: led_q, active: active_q};
	assign stat_next = '{led: led_d, active: active_d};

endmodule
`default_nettype wire

@@ rtl/multi_channel_led_blinker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_led_blinker
// Seven-channel LED blink controller driven by a command stream of ticks,
// blink start and stop, and direct led on and off.
// ----------------------------------------------------------------------------
// result: a command's result is registered in the output register or skid buffer
// throughput: one command per cycle while the skid buffer is empty, all channels
//   update in parallel in a single pass of next-state logic; a two-entry output
//   register and skid buffer keeps input ready off the output ready path
// reset: all channels inactive, all leds off, counts zero; no clearing pass
// ----------------------------------------------------------------------------
module multi_channel_led_blinker
	import mclb_pkg::*;
#(
	parameter int NUM_LEDS = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [2:0] command, [5:3] led_index, [21:6] period_ms, [37:22] duration_ms
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [6:0] led_state, [13:7] blinking
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int OFS_IDX = CMD_W;
	localparam int OFS_PER = CMD_W + IDX_W;
	localparam int OFS_DUR = CMD_W + IDX_W + PERIOD_W;

	logic                  accept;
	cmd_t                  cmd;
	logic [IDX_W-1:0]      idx;
	logic [PERIOD_W-1:0]   period;
	logic [DURATION_W-1:0] duration;
	logic                  idx_ok;

	chan_ctrl_t ctrl      [NUM_LEDS];
	chan_stat_t stat      [NUM_LEDS];
	chan_stat_t stat_next [NUM_LEDS];

	logic [OUT_W-1:0] led_vec;
	logic [OUT_W-1:0] act_vec;

	logic                  out_v_q;
	logic [OUT_BITS-1:0]   out_q;
	logic                  skid_v_q;
	logic [OUT_BITS-1:0]   skid_q;

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;

	assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
	assign idx      = s_tdata[OFS_IDX +: IDX_W];
	assign period   = s_tdata[OFS_PER +: PERIOD_W];
	assign duration = s_tdata[OFS_DUR +: DURATION_W];
	assign idx_ok   = (32'(idx) < NUM_LEDS);

	// per-channel command decode
	always_comb begin
		for (int i = 0; i < NUM_LEDS; i++) begin
			logic hit;
			hit     = accept && idx_ok && (32'(idx) == i);
			ctrl[i] = '0;
			unique case (cmd)
				CMD_TICK:    ctrl[i].tick    = accept;
				CMD_START:   ctrl[i].start   = hit;
				CMD_STOP:    ctrl[i].stop    = hit;
				CMD_LED_ON:  ctrl[i].led_on  = hit;
				CMD_LED_OFF: ctrl[i].led_off = hit;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_LEDS; g++) begin : g_chan
		mclb_channel u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[g]),
			.period    (period),
			.duration  (duration),
			.stat      (stat[g]),
			.stat_next (stat_next[g])
		);
	end

	for (genvar k = 0; k < OUT_W; k++) begin : g_out
		if (k < NUM_LEDS) begin : g_used
			assign led_vec[k] = stat_next[k].led;
			assign act_vec[k] = stat_next[k].active;
		end else begin : g_absent
			assign led_vec[k] = 1'b0;
			assign act_vec[k] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_v_q || m_tready) begin
				out_q <= {act_vec, led_vec};
			end else begin
				skid_q <= {act_vec, led_vec};
			end
		end else if (m_tready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_q};

	// skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output entry");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted command produced no result");

	a_start_activates: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl[0].start |=> stat[0].active)
		else $error("start did not activate channel");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl[0].stop |=> (!stat[0].active && !stat[0].led))
		else $error("stop left channel active or lit");

endmodule
`default_nettype wire
